>>> src/y2b_pkg.sv
// Shared types, widths and Q8 coefficients for the YUYV to BGR24 converter.
// No dependencies; imported by every module of the block.
package y2b_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int WIDTH_W   = 13;
   localparam int COLUMN_W  = 12;
   localparam int PAD_W     = 2;
   localparam int TERM_W    = 18;
   localparam int SUM_W     = 19;
   localparam int MAX_WIDTH = 4096;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 13'd2;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH & ~1);

   // Q8 coefficients, BT.601
   localparam logic signed [TERM_W-1:0] CF_RV = 18'sd359;
   localparam logic signed [TERM_W-1:0] CF_BU = 18'sd454;
   localparam logic signed [TERM_W-1:0] CF_GU = 18'sd88;
   localparam logic signed [TERM_W-1:0] CF_GV = 18'sd183;

   localparam logic signed [SAMPLE_W:0] CHROMA_OFFSET = 9'sd128;

   typedef struct packed {
      logic signed [TERM_W-1:0] blue_term;
      logic signed [TERM_W-1:0] green_term;
      logic signed [TERM_W-1:0] red_term;
   } chroma_terms_type;

   typedef struct packed {
      logic             row_end;
      logic [PAD_W-1:0] pad_bytes;
   } row_info_type;

endpackage

>>> src/y2b_chroma.sv
// Shared chroma products for one YUYV group (both pixels use them).
// Depends on y2b_pkg.
module y2b_chroma
   import y2b_pkg::*;
(
   input  logic [SAMPLE_W-1:0] chroma_blue,
   input  logic [SAMPLE_W-1:0] chroma_red,
   output chroma_terms_type    terms
);

   logic signed [SAMPLE_W:0] du;
   logic signed [SAMPLE_W:0] dv;
   logic signed [TERM_W-1:0] du_ext;
   logic signed [TERM_W-1:0] dv_ext;

   assign du     = $signed({1'b0, chroma_blue}) - CHROMA_OFFSET;
   assign dv     = $signed({1'b0, chroma_red}) - CHROMA_OFFSET;
   assign du_ext = TERM_W'(du);
   assign dv_ext = TERM_W'(dv);

   always_comb begin
      terms.blue_term  = CF_BU * du_ext;
      terms.green_term = -(CF_GU * du_ext) - (CF_GV * dv_ext);
      terms.red_term   = CF_RV * dv_ext;
   end

endmodule

>>> src/y2b_pixel.sv
// One BGR pixel from a luma sample and the shared chroma terms: add, floor, clamp.
// Depends on y2b_pkg.
module y2b_pixel
   import y2b_pkg::*;
(
   input  logic [SAMPLE_W-1:0] luma,
   input  chroma_terms_type    terms,
   output logic [SAMPLE_W-1:0] blue,
   output logic [SAMPLE_W-1:0] green,
   output logic [SAMPLE_W-1:0] red
);

   // arithmetic shift floors negative sums
   function automatic logic [SAMPLE_W-1:0] clamp_q8(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] v;
      begin
         v = sum >>> 8;
         if (v < 0) begin
            clamp_q8 = '0;
         end else if (v > 255) begin
            clamp_q8 = '1;
         end else begin
            clamp_q8 = v[SAMPLE_W-1:0];
         end
      end
   endfunction

   logic signed [SUM_W-1:0] base;

   assign base  = $signed({3'b000, luma, 8'h00});
   assign blue  = clamp_q8(base + SUM_W'(terms.blue_term));
   assign green = clamp_q8(base + SUM_W'(terms.green_term));
   assign red   = clamp_q8(base + SUM_W'(terms.red_term));

endmodule

>>> src/y2b_row_tracker.sv
// Row width register and pair column counter; flags the last pair of a row.
// Depends on y2b_pkg.
module y2b_row_tracker
   import y2b_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [WIDTH_W-1:0] csr_write_data,
   input  logic               advance,
   output row_info_type       row_info
);

   logic [WIDTH_W-1:0]  row_width_ff;
   logic [WIDTH_W-1:0]  row_width_in;
   logic [COLUMN_W-1:0] col_ff;
   logic [COLUMN_W-1:0] col_in;
   logic [WIDTH_W-1:0]  eff_width;
   logic [WIDTH_W-1:0]  pairs;
   logic [WIDTH_W-1:0]  col_next;
   logic                last_pair;

   always_comb begin
      eff_width = {row_width_ff[WIDTH_W-1:1], 1'b0};
      if (eff_width < WIDTH_MIN) begin
         eff_width = WIDTH_MIN;
      end else if (eff_width > WIDTH_MAX) begin
         eff_width = WIDTH_MAX;
      end
      pairs     = eff_width >> 1;
      col_next  = {1'b0, col_ff} + 13'd1;
      last_pair = (col_next >= pairs);

      row_info.row_end   = last_pair;
      // -3w mod 4 equals w mod 4
      row_info.pad_bytes = last_pair ? eff_width[PAD_W-1:0] : '0;

      row_width_in = csr_write_enable ? csr_write_data : row_width_ff;
      col_in       = col_ff;
      if (advance) begin
         col_in = last_pair ? '0 : col_next[COLUMN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_RESET;
         col_ff       <= '0;
      end else begin
         row_width_ff <= row_width_in;
         col_ff       <= col_in;
      end
   end

   a_row_end_wraps: assert property (@(posedge clock) disable iff (reset)
      advance && last_pair |=> col_ff == '0)
      else $error("column counter did not return to zero at row end");

   a_pad_only_at_row_end: assert property (@(posedge clock) disable iff (reset)
      !last_pair |-> row_info.pad_bytes == '0)
      else $error("padding reported away from row end");

endmodule

>>> src/yuyv_to_bgr24_converter_top.sv
// Top level of the YUYV 4:2:2 to BGR24 converter.
// Depends on y2b_pkg, y2b_chroma, y2b_pixel and y2b_row_tracker.
//
// Usage
//   req_*  : one YUYV group per transfer (Y0, U, Y1, V).
//   rsp_*  : one transfer per group: two BGR pixels, a row end flag and the
//            number of zero bytes that bring the row to a 4-byte boundary.
//   csr_*  : row width in pixels; write only while the block is idle.
//            Odd widths round down, and the width is held to 2..4096.
// From a req transfer to rsp_valid, the group is held in an input
// register, converted by constant multiplies, adds and clamps, and caught
// in the result register once the result stage is free.
// Throughput is one group per cycle while rsp_ready is high; the result and
// input registers each take a new transfer once the stage behind them moves.
// When the receiver stalls, the result holds and the input register fills;
// req_ready drops only once both stages hold data.
// Reset empties both stages, sets the width to 640 and the column to zero.
module yuyv_to_bgr24_converter_top
   import y2b_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_luma_first,
   input  logic [SAMPLE_W-1:0] req_chroma_blue,
   input  logic [SAMPLE_W-1:0] req_luma_second,
   input  logic [SAMPLE_W-1:0] req_chroma_red,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_blue_first,
   output logic [SAMPLE_W-1:0] rsp_green_first,
   output logic [SAMPLE_W-1:0] rsp_red_first,
   output logic [SAMPLE_W-1:0] rsp_blue_second,
   output logic [SAMPLE_W-1:0] rsp_green_second,
   output logic [SAMPLE_W-1:0] rsp_red_second,
   output logic                rsp_row_end,
   output logic [PAD_W-1:0]    rsp_pad_bytes,

   input  logic                csr_write_enable,
   input  logic [WIDTH_W-1:0]  csr_write_data
);

   // input register
   logic                s0_valid_ff, s0_valid_in;
   logic [SAMPLE_W-1:0] s0_luma0_ff, s0_luma1_ff, s0_u_ff, s0_v_ff;
   row_info_type        s0_row_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] b0_ff, g0_ff, r0_ff, b1_ff, g1_ff, r1_ff;
   row_info_type        rsp_row_ff;

   logic                s0_ready, s1_ready, req_take, s0_move;
   row_info_type        row_info;
   chroma_terms_type    terms;
   logic [SAMPLE_W-1:0] b0, g0, r0, b1, g1, r1;

   assign s1_ready  = !rsp_valid_ff || rsp_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_ready = s0_ready;
   assign req_take  = req_valid && s0_ready;
   assign s0_move   = s0_valid_ff && s1_ready;

   // Row position is settled as each group enters, so order is kept.
   y2b_row_tracker u_row (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .advance          (req_take),
      .row_info         (row_info)
   );

   y2b_chroma u_chroma (
      .chroma_blue (s0_u_ff),
      .chroma_red  (s0_v_ff),
      .terms       (terms)
   );

   y2b_pixel u_pixel_first (
      .luma  (s0_luma0_ff),
      .terms (terms),
      .blue  (b0),
      .green (g0),
      .red   (r0)
   );

   y2b_pixel u_pixel_second (
      .luma  (s0_luma1_ff),
      .terms (terms),
      .blue  (b1),
      .green (g1),
      .red   (r1)
   );

   always_comb begin
      // input stage: fill on a req transfer, drain when the result moves on
      s0_valid_in = s0_valid_ff;
      if (req_take) begin
         s0_valid_in = 1'b1;
      end else if (s0_move) begin
         s0_valid_in = 1'b0;
      end
      // result stage
      rsp_valid_in = rsp_valid_ff;
      if (s0_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_luma0_ff <= req_luma_first;
         s0_u_ff     <= req_chroma_blue;
         s0_luma1_ff <= req_luma_second;
         s0_v_ff     <= req_chroma_red;
         s0_row_ff   <= row_info;
      end
      if (s0_move) begin
         b0_ff      <= b0;
         g0_ff      <= g0;
         r0_ff      <= r0;
         b1_ff      <= b1;
         g1_ff      <= g1;
         r1_ff      <= r1;
         rsp_row_ff <= s0_row_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blue_first   = b0_ff;
   assign rsp_green_first  = g0_ff;
   assign rsp_red_first    = r0_ff;
   assign rsp_blue_second  = b1_ff;
   assign rsp_green_second = g1_ff;
   assign rsp_red_second   = r1_ff;
   assign rsp_row_end      = rsp_row_ff.row_end;
   assign rsp_pad_bytes    = rsp_row_ff.pad_bytes;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while both stages are full and stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s0_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !s0_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared without a group in the input register");

endmodule
